// ----- hw/rtl/ec2d_pkg.sv -----
// Shared types and constants of the 2D elastic collision pipeline.
package ec2d_pkg;

    localparam int S_QBITS = 46;   // quotient bits of the normal factor
    localparam int R_QBITS = 18;   // quotient bits of the mass ratios
    localparam int N_W     = 81;   // dot product shifted up by 16
    localparam int DEN_W   = 64;   // separation squared
    localparam int TOT_W   = 33;   // total mass
    localparam int RNUM_W  = 49;   // mass shifted up by 17

    localparam logic [16:0] DAMP_RESET = 17'h10000;
    localparam logic [45:0] S_LIMIT    = {S_QBITS{1'b1}};
    localparam logic [33:0] DV_CAP     = 34'h2_0000_0000;

    // per-request context carried alongside the arithmetic
    typedef struct packed {
        logic [31:0] vax;
        logic [31:0] vay;
        logic [31:0] vbx;
        logic [31:0] vby;
        logic        degen;
        logic [32:0] dmx;
        logic [32:0] dmy;
        logic        dnx;
        logic        dny;
        logic        sneg;
    } ctx_t;

    typedef struct packed {
        ctx_t                ctx;
        logic [N_W-1:0]      rem_s;
        logic [DEN_W-1:0]    den_s;
        logic [S_QBITS-1:0]  q_s;
        logic                sat;
        logic [RNUM_W-1:0]   rem_a;
        logic [RNUM_W-1:0]   rem_b;
        logic [TOT_W-1:0]    tot;
        logic [R_QBITS-1:0]  ra;
        logic [R_QBITS-1:0]  rb;
    } div_t;

    typedef struct packed {
        logic [31:0] nvax;
        logic [31:0] nvay;
        logic [31:0] nvbx;
        logic [31:0] nvby;
        logic        degen;
    } res_t;

endpackage

// ----- hw/rtl/ec2d_front.sv -----
// Front stages: differences, dot product, separation squared, saturation check.
module ec2d_front (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               en,
    input  logic               in_valid,
    input  logic [31:0]        pax,
    input  logic [31:0]        pay,
    input  logic [31:0]        pbx,
    input  logic [31:0]        pby,
    input  logic [31:0]        vax,
    input  logic [31:0]        vay,
    input  logic [31:0]        vbx,
    input  logic [31:0]        vby,
    input  logic [31:0]        ma,
    input  logic [31:0]        mb,
    input  logic [31:0]        sep,
    output logic               out_valid,
    output ec2d_pkg::div_t     out_data
);
    import ec2d_pkg::*;

    // stage A
    logic        a_valid_reg;
    ctx_t        a_ctx_reg;
    logic [32:0] a_mux_reg, a_muy_reg;
    logic        a_nux_reg, a_nuy_reg;
    logic [31:0] a_ma_reg, a_mb_reg, a_sep_reg;
    logic [32:0] a_tot_reg;
    // stage B
    logic        b_valid_reg;
    ctx_t        b_ctx_reg;
    logic [63:0] b_m1_reg, b_m2_reg, b_den_reg;
    logic        b_n1_reg, b_n2_reg;
    logic [31:0] b_ma_reg, b_mb_reg;
    logic [32:0] b_tot_reg;
    // stage C
    logic        c_valid_reg;
    ctx_t        c_ctx_reg;
    logic [N_W-1:0] c_n_reg;
    logic [63:0] c_den_reg;
    logic [RNUM_W-1:0] c_na_reg, c_nb_reg;
    logic [32:0] c_tot_reg;
    // stage D
    logic        d_valid_reg;
    div_t        d_data_reg;

    logic [32:0] dx, dy, ux, uy;
    ctx_t        a_ctx_next;
    logic [65:0] p1, p2;
    logic [64:0] dot;
    logic        sneg;
    ctx_t        c_ctx_next;
    logic [109:0] n_wide, den_wide;
    div_t        d_data_next;

    always_comb begin
        dx = {pbx[31], pbx} - {pax[31], pax};
        dy = {pby[31], pby} - {pay[31], pay};
        ux = {vbx[31], vbx} - {vax[31], vax};
        uy = {vby[31], vby} - {vay[31], vay};
        a_ctx_next.vax   = vax;
        a_ctx_next.vay   = vay;
        a_ctx_next.vbx   = vbx;
        a_ctx_next.vby   = vby;
        a_ctx_next.degen = (sep == 32'd0) || ((ma == 32'd0) && (mb == 32'd0));
        a_ctx_next.dmx   = dx[32] ? (33'd0 - dx) : dx;
        a_ctx_next.dmy   = dy[32] ? (33'd0 - dy) : dy;
        a_ctx_next.dnx   = dx[32];
        a_ctx_next.dny   = dy[32];
        a_ctx_next.sneg  = 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a_ctx_reg <= a_ctx_next;
            a_mux_reg <= ux[32] ? (33'd0 - ux) : ux;
            a_muy_reg <= uy[32] ? (33'd0 - uy) : uy;
            a_nux_reg <= ux[32];
            a_nuy_reg <= uy[32];
            a_ma_reg  <= ma;
            a_mb_reg  <= mb;
            a_sep_reg <= sep;
            a_tot_reg <= {1'b0, ma} + {1'b0, mb};
        end
    end

    // stage B: exact magnitudes of the dot terms, wrapped to 64 bits
    assign p1 = a_mux_reg * a_ctx_reg.dmx;
    assign p2 = a_muy_reg * a_ctx_reg.dmy;

    always_ff @(posedge aclk) begin
        if (en) begin
            b_ctx_reg <= a_ctx_reg;
            b_m1_reg  <= p1[63:0];
            b_m2_reg  <= p2[63:0];
            b_n1_reg  <= a_nux_reg ^ a_ctx_reg.dnx;
            b_n2_reg  <= a_nuy_reg ^ a_ctx_reg.dny;
            b_den_reg <= a_sep_reg * a_sep_reg;
            b_ma_reg  <= a_ma_reg;
            b_mb_reg  <= a_mb_reg;
            b_tot_reg <= a_tot_reg;
        end
    end

    // stage C: signed sum of the two terms as magnitude and sign
    always_comb begin
        if (b_n1_reg == b_n2_reg) begin
            dot  = {1'b0, b_m1_reg} + {1'b0, b_m2_reg};
            sneg = b_n1_reg;
        end else if (b_m1_reg >= b_m2_reg) begin
            dot  = {1'b0, b_m1_reg - b_m2_reg};
            sneg = b_n1_reg;
        end else begin
            dot  = {1'b0, b_m2_reg - b_m1_reg};
            sneg = b_n2_reg;
        end
        c_ctx_next      = b_ctx_reg;
        c_ctx_next.sneg = sneg;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            c_ctx_reg      <= c_ctx_next;
            c_n_reg        <= {dot, 16'd0};
            c_den_reg      <= b_den_reg;
            c_na_reg       <= {b_mb_reg, 17'd0};
            c_nb_reg       <= {b_ma_reg, 17'd0};
            c_tot_reg      <= b_tot_reg;
        end
    end

    // stage D: quotient would not fit in 46 bits
    always_comb begin
        n_wide   = {29'd0, c_n_reg};
        den_wide = {c_den_reg, 46'd0};
        d_data_next.ctx   = c_ctx_reg;
        d_data_next.rem_s = c_n_reg;
        d_data_next.den_s = c_den_reg;
        d_data_next.q_s   = '0;
        d_data_next.sat   = n_wide >= den_wide;
        d_data_next.rem_a = c_na_reg;
        d_data_next.rem_b = c_nb_reg;
        d_data_next.tot   = c_tot_reg;
        d_data_next.ra    = '0;
        d_data_next.rb    = '0;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            d_data_reg <= d_data_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
        end else if (en) begin
            a_valid_reg <= in_valid;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
            d_valid_reg <= c_valid_reg;
        end
    end

    assign out_valid = d_valid_reg;
    assign out_data  = d_data_reg;

endmodule

// ----- hw/rtl/ec2d_div_stage.sv -----
// One restoring-division step for the normal factor and, early on, the mass ratios.
module ec2d_div_stage #(
    parameter int STEP = 0
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            en,
    input  logic            in_valid,
    input  ec2d_pkg::div_t  in_data,
    output logic            out_valid,
    output ec2d_pkg::div_t  out_data
);
    import ec2d_pkg::*;

    localparam int SB = S_QBITS - 1 - STEP;

    logic        valid_reg;
    div_t        data_reg;
    div_t        data_next;
    logic [109:0] s_rem_w, s_trial, s_diff;
    logic [RNUM_W-1:0]  rem_a_n, rem_b_n;
    logic [R_QBITS-1:0] ra_n, rb_n;

    always_comb begin
        s_rem_w = {29'd0, in_data.rem_s};
        s_trial = {46'd0, in_data.den_s} << SB;
        s_diff  = s_rem_w - s_trial;
        data_next = in_data;
        if (s_rem_w >= s_trial) begin
            data_next.rem_s   = s_diff[N_W-1:0];
            data_next.q_s[SB] = 1'b1;
        end
        data_next.rem_a = rem_a_n;
        data_next.rem_b = rem_b_n;
        data_next.ra    = ra_n;
        data_next.rb    = rb_n;
    end

    generate
        if (STEP < R_QBITS) begin : g_ratio
            localparam int RB = R_QBITS - 1 - STEP;
            logic [49:0] r_trial, a_w, b_w, a_d, b_d;
            always_comb begin
                r_trial = {17'd0, in_data.tot} << RB;
                a_w     = {1'b0, in_data.rem_a};
                b_w     = {1'b0, in_data.rem_b};
                a_d     = a_w - r_trial;
                b_d     = b_w - r_trial;
                rem_a_n = in_data.rem_a;
                rem_b_n = in_data.rem_b;
                ra_n    = in_data.ra;
                rb_n    = in_data.rb;
                if (a_w >= r_trial) begin
                    rem_a_n  = a_d[RNUM_W-1:0];
                    ra_n[RB] = 1'b1;
                end
                if (b_w >= r_trial) begin
                    rem_b_n  = b_d[RNUM_W-1:0];
                    rb_n[RB] = 1'b1;
                end
            end
        end else begin : g_pass
            always_comb begin
                rem_a_n = in_data.rem_a;
                rem_b_n = in_data.rem_b;
                ra_n    = in_data.ra;
                rb_n    = in_data.rb;
            end
        end
    endgenerate

    always_ff @(posedge aclk) begin
        if (en) begin
            data_reg <= data_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// ----- hw/rtl/ec2d_divider.sv -----
// Chain of division steps, one quotient bit per stage.
module ec2d_divider (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            en,
    input  logic            in_valid,
    input  ec2d_pkg::div_t  in_data,
    output logic            out_valid,
    output ec2d_pkg::div_t  out_data
);
    import ec2d_pkg::*;

    logic [S_QBITS:0] v_chain;
    div_t             d_chain [S_QBITS+1];

    assign v_chain[0] = in_valid;
    assign d_chain[0] = in_data;

    generate
        for (genvar k = 0; k < S_QBITS; k++) begin : g_step
            ec2d_div_stage #(.STEP(k)) u_step (
                .aclk      (aclk),
                .aresetn   (aresetn),
                .en        (en),
                .in_valid  (v_chain[k]),
                .in_data   (d_chain[k]),
                .out_valid (v_chain[k+1]),
                .out_data  (d_chain[k+1])
            );
        end
    endgenerate

    assign out_valid = v_chain[S_QBITS];
    assign out_data  = d_chain[S_QBITS];

endmodule

// ----- hw/rtl/ec2d_back.sv -----
// Back stages: damped factors, velocity change per axis, saturated update.
module ec2d_back (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            en,
    input  logic            in_valid,
    input  ec2d_pkg::div_t  in_data,
    input  logic [16:0]     damping,
    output logic            out_valid,
    output ec2d_pkg::res_t  out_data
);
    import ec2d_pkg::*;

    logic        f1_valid_reg, f2_valid_reg, f3_valid_reg;
    logic        f4_valid_reg, f5_valid_reg, f6_valid_reg;
    ctx_t        f1_ctx_reg, f2_ctx_reg, f3_ctx_reg, f4_ctx_reg, f5_ctx_reg;
    logic [45:0] f1_s_reg;
    logic [18:0] f1_fa_reg, f1_fb_reg;
    logic [41:0] f2_pha_reg, f2_pla_reg, f2_phb_reg, f2_plb_reg;
    logic [63:0] f3_ka_reg, f3_kb_reg;
    logic [64:0] f4_p_reg [8];
    logic [33:0] f5_m_reg [4];
    res_t        f6_res_reg;

    logic [34:0] fa_w, fb_w;
    logic [64:0] ka_w, kb_w;
    logic [32:0] dsel [4];
    logic [31:0] ksel [4];
    logic [65:0] v_w [4];
    logic [31:0] vel [4];
    logic        neg [4];
    logic [34:0] r_w [4];
    logic [31:0] r_sat [4];

    // F1
    assign fa_w = in_data.ra * damping;
    assign fb_w = in_data.rb * damping;

    always_ff @(posedge aclk) begin
        if (en) begin
            f1_ctx_reg <= in_data.ctx;
            f1_s_reg   <= in_data.sat ? S_LIMIT : in_data.q_s;
            f1_fa_reg  <= fa_w[34:16];
            f1_fb_reg  <= fb_w[34:16];
        end
    end

    // F2: factor times normal, split into two partial products
    always_ff @(posedge aclk) begin
        if (en) begin
            f2_ctx_reg <= f1_ctx_reg;
            f2_pha_reg <= f1_s_reg[45:23] * f1_fa_reg;
            f2_pla_reg <= f1_s_reg[22:0] * f1_fa_reg;
            f2_phb_reg <= f1_s_reg[45:23] * f1_fb_reg;
            f2_plb_reg <= f1_s_reg[22:0] * f1_fb_reg;
        end
    end

    // F3
    assign ka_w = {f2_pha_reg, 23'd0} + {23'd0, f2_pla_reg};
    assign kb_w = {f2_phb_reg, 23'd0} + {23'd0, f2_plb_reg};

    always_ff @(posedge aclk) begin
        if (en) begin
            f3_ctx_reg <= f2_ctx_reg;
            f3_ka_reg  <= ka_w[63:0];
            f3_kb_reg  <= kb_w[63:0];
        end
    end

    // F4: lanes are a.x, a.y, b.x, b.y; each k split into halves
    always_comb begin
        dsel[0] = f3_ctx_reg.dmx;
        dsel[1] = f3_ctx_reg.dmy;
        dsel[2] = f3_ctx_reg.dmx;
        dsel[3] = f3_ctx_reg.dmy;
        ksel[0] = f3_ka_reg[63:32];
        ksel[1] = f3_ka_reg[31:0];
        ksel[2] = f3_kb_reg[63:32];
        ksel[3] = f3_kb_reg[31:0];
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            f4_ctx_reg <= f3_ctx_reg;
            for (int i = 0; i < 4; i++) begin
                f4_p_reg[2*i]   <= ksel[(i/2)*2] * dsel[i];
                f4_p_reg[2*i+1] <= ksel[(i/2)*2+1] * dsel[i];
            end
        end
    end

    // F5: drop 32 fraction bits and cap
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            v_w[i] = {1'b0, f4_p_reg[2*i]} + {33'd0, f4_p_reg[2*i+1][64:32]};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            f5_ctx_reg <= f4_ctx_reg;
            for (int i = 0; i < 4; i++) begin
                f5_m_reg[i] <= (v_w[i] > {32'd0, DV_CAP}) ? DV_CAP : v_w[i][33:0];
            end
        end
    end

    // F6: apply change, b moves opposite to a
    always_comb begin
        vel[0] = f5_ctx_reg.vax;
        vel[1] = f5_ctx_reg.vay;
        vel[2] = f5_ctx_reg.vbx;
        vel[3] = f5_ctx_reg.vby;
        neg[0] = f5_ctx_reg.sneg ^ f5_ctx_reg.dnx;
        neg[1] = f5_ctx_reg.sneg ^ f5_ctx_reg.dny;
        neg[2] = !neg[0];
        neg[3] = !neg[1];
        for (int i = 0; i < 4; i++) begin
            if (neg[i]) begin
                r_w[i] = {{3{vel[i][31]}}, vel[i]} - {1'b0, f5_m_reg[i]};
            end else begin
                r_w[i] = {{3{vel[i][31]}}, vel[i]} + {1'b0, f5_m_reg[i]};
            end
            if (!r_w[i][34] && (r_w[i][33:31] != 3'b000)) begin
                r_sat[i] = 32'h7FFF_FFFF;
            end else if (r_w[i][34] && (r_w[i][33:31] != 3'b111)) begin
                r_sat[i] = 32'h8000_0000;
            end else begin
                r_sat[i] = r_w[i][31:0];
            end
            if (f5_ctx_reg.degen) begin
                r_sat[i] = vel[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            f6_res_reg.nvax  <= r_sat[0];
            f6_res_reg.nvay  <= r_sat[1];
            f6_res_reg.nvbx  <= r_sat[2];
            f6_res_reg.nvby  <= r_sat[3];
            f6_res_reg.degen <= f5_ctx_reg.degen;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f1_valid_reg <= 1'b0;
            f2_valid_reg <= 1'b0;
            f3_valid_reg <= 1'b0;
            f4_valid_reg <= 1'b0;
            f5_valid_reg <= 1'b0;
            f6_valid_reg <= 1'b0;
        end else if (en) begin
            f1_valid_reg <= in_valid;
            f2_valid_reg <= f1_valid_reg;
            f3_valid_reg <= f2_valid_reg;
            f4_valid_reg <= f3_valid_reg;
            f5_valid_reg <= f4_valid_reg;
            f6_valid_reg <= f5_valid_reg;
        end
    end

    assign out_valid = f6_valid_reg;
    assign out_data  = f6_res_reg;

endmodule

// ----- hw/rtl/elastic_collision_2d.sv -----
// Top level of the 2D elastic collision pipeline.
//
//  channel | dir | width | carries
//  s_      | in  | 352   | one colliding pair per request
//  m_      | out | 128+1 | updated velocities, degenerate flag in tuser
//  cfg_    | in  | 17    | damping, Q1.16
//
// One request per cycle unless m_tready stalls; 4 front, 46 divider and 6 back stages,
// most of them in the one-bit-per-stage divider for the normal factor.
// Reset clears all valid bits and sets damping to one.
// A stall on m_tready freezes every stage; s_tready follows it in the same cycle.
module elastic_collision_2d (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    // pos_a_x, pos_a_y, pos_b_x, pos_b_y, vel_a_x, vel_a_y, vel_b_x, vel_b_y,
    // mass_a, mass_b, separation (32 bits each)
    input  logic [351:0]  s_tdata,
    output logic          m_tvalid,
    input  logic          m_tready,
    // new_vel_a_x, new_vel_a_y, new_vel_b_x, new_vel_b_y (32 bits each)
    output logic [127:0]  m_tdata,
    // degenerate
    output logic          m_tuser,
    input  logic          cfg_wen,
    input  logic [16:0]   cfg_wdata
);
    import ec2d_pkg::*;

    logic [16:0] damp_reg;
    logic        en;
    logic        fr_valid, dv_valid, bk_valid;
    div_t        fr_data, dv_data;
    res_t        bk_data;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            damp_reg <= DAMP_RESET;
        end else if (cfg_wen) begin
            damp_reg <= cfg_wdata;
        end
    end

    assign en       = !bk_valid || m_tready;
    assign s_tready = en;

    ec2d_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_tvalid),
        .pax       (s_tdata[31:0]),
        .pay       (s_tdata[63:32]),
        .pbx       (s_tdata[95:64]),
        .pby       (s_tdata[127:96]),
        .vax       (s_tdata[159:128]),
        .vay       (s_tdata[191:160]),
        .vbx       (s_tdata[223:192]),
        .vby       (s_tdata[255:224]),
        .ma        (s_tdata[287:256]),
        .mb        (s_tdata[319:288]),
        .sep       (s_tdata[351:320]),
        .out_valid (fr_valid),
        .out_data  (fr_data)
    );

    ec2d_divider u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (fr_valid),
        .in_data   (fr_data),
        .out_valid (dv_valid),
        .out_data  (dv_data)
    );

    ec2d_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (dv_valid),
        .in_data   (dv_data),
        .damping   (damp_reg),
        .out_valid (bk_valid),
        .out_data  (bk_data)
    );

    assign m_tvalid = bk_valid;
    assign m_tdata  = {bk_data.nvby, bk_data.nvbx, bk_data.nvay, bk_data.nvax};
    assign m_tuser  = bk_data.degen;

endmodule
